FILE: rtl/mwa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwa_pkg
// Shared types, microcode layout and control store of the accumulator ALU.
// ----------------------------------------------------------------------------
package mwa_pkg;

  localparam int DataWidthDef = 32;
  localparam int CmdW         = 4;
  localparam int OperandW     = 32;
  localparam int CfgW         = 6;
  localparam logic [CfgW-1:0] ResultWidthRst = 6'd32;
  localparam int PcW          = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD   = 4'd0,
    CMD_ADD    = 4'd1,
    CMD_SUB    = 4'd2,
    CMD_MUL    = 4'd3,
    CMD_DIV    = 4'd4,
    CMD_AND    = 4'd5,
    CMD_OR     = 4'd6,
    CMD_XOR    = 4'd7,
    CMD_SQRT   = 4'd8,
    CMD_SQUARE = 4'd9,
    CMD_SHL    = 4'd10,
    CMD_SHR    = 4'd11,
    CMD_NOT    = 4'd12
  } cmd_e;

  // datapath action of one microcode step
  typedef enum logic [2:0] {
    DP_NONE      = 3'd0,
    DP_MUL_AB    = 3'd1,
    DP_MUL_SQ    = 3'd2,
    DP_DIV_INIT  = 3'd3,
    DP_DIV_STEP  = 3'd4,
    DP_SQRT_INIT = 3'd5,
    DP_SQRT_STEP = 3'd6,
    DP_COMMIT    = 3'd7
  } dp_op_e;

  // source of the new accumulator value at commit
  typedef enum logic [3:0] {
    RES_A    = 4'd0,
    RES_ADD  = 4'd1,
    RES_SUB  = 4'd2,
    RES_PROD = 4'd3,
    RES_QUO  = 4'd4,
    RES_AND  = 4'd5,
    RES_OR   = 4'd6,
    RES_XOR  = 4'd7,
    RES_ROOT = 4'd8,
    RES_SHL  = 4'd9,
    RES_SHR  = 4'd10,
    RES_NOT  = 4'd11,
    RES_KEEP = 4'd12
  } res_sel_e;

  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_DIV  = 2'd1,
    CNT_SQRT = 2'd2
  } cnt_sel_e;

  typedef enum logic [1:0] {
    J_NEXT = 2'd0,
    J_LOOP = 2'd1,
    J_DONE = 2'd2
  } jump_e;

  typedef struct packed {
    dp_op_e           dp_op;
    res_sel_e         res_sel;
    cnt_sel_e         cnt_sel;
    jump_e            jump;
    logic [PcW-1:0]   target;
  } ctl_word_t;

  // sequencer to datapath
  typedef struct packed {
    logic     capture;
    logic     fire;
    dp_op_e   dp_op;
    res_sel_e res_sel;
  } dp_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic out_stall;
  } dp_status_t;

  // control store addresses
  localparam logic [PcW-1:0] PC_LOAD      = 5'd0;
  localparam logic [PcW-1:0] PC_ADD       = 5'd1;
  localparam logic [PcW-1:0] PC_SUB       = 5'd2;
  localparam logic [PcW-1:0] PC_AND       = 5'd3;
  localparam logic [PcW-1:0] PC_OR        = 5'd4;
  localparam logic [PcW-1:0] PC_XOR       = 5'd5;
  localparam logic [PcW-1:0] PC_SHL       = 5'd6;
  localparam logic [PcW-1:0] PC_SHR       = 5'd7;
  localparam logic [PcW-1:0] PC_NOT       = 5'd8;
  localparam logic [PcW-1:0] PC_KEEP      = 5'd9;
  localparam logic [PcW-1:0] PC_MUL       = 5'd10;
  localparam logic [PcW-1:0] PC_MUL_WB    = 5'd11;
  localparam logic [PcW-1:0] PC_SQUARE    = 5'd12;
  localparam logic [PcW-1:0] PC_SQUARE_WB = 5'd13;
  localparam logic [PcW-1:0] PC_DIV       = 5'd14;
  localparam logic [PcW-1:0] PC_DIV_LOOP  = 5'd15;
  localparam logic [PcW-1:0] PC_DIV_WB    = 5'd16;
  localparam logic [PcW-1:0] PC_SQRT      = 5'd17;
  localparam logic [PcW-1:0] PC_SQRT_LOOP = 5'd18;
  localparam logic [PcW-1:0] PC_SQRT_WB   = 5'd19;

  function automatic ctl_word_t step_word(dp_op_e op, res_sel_e rs, cnt_sel_e cs,
                                          jump_e jp, logic [PcW-1:0] tgt);
    ctl_word_t w;
    w.dp_op   = op;
    w.res_sel = rs;
    w.cnt_sel = cs;
    w.jump    = jp;
    w.target  = tgt;
    return w;
  endfunction

  function automatic ctl_word_t commit_word(res_sel_e rs);
    return step_word(DP_COMMIT, rs, CNT_NONE, J_DONE, PC_LOAD);
  endfunction

  // microprogram
  function automatic ctl_word_t rom_word(logic [PcW-1:0] pc);
    ctl_word_t w;
    w = step_word(DP_NONE, RES_KEEP, CNT_NONE, J_DONE, PC_LOAD);
    unique case (pc)
      PC_LOAD:      w = commit_word(RES_A);
      PC_ADD:       w = commit_word(RES_ADD);
      PC_SUB:       w = commit_word(RES_SUB);
      PC_AND:       w = commit_word(RES_AND);
      PC_OR:        w = commit_word(RES_OR);
      PC_XOR:       w = commit_word(RES_XOR);
      PC_SHL:       w = commit_word(RES_SHL);
      PC_SHR:       w = commit_word(RES_SHR);
      PC_NOT:       w = commit_word(RES_NOT);
      PC_KEEP:      w = commit_word(RES_KEEP);
      PC_MUL:       w = step_word(DP_MUL_AB, RES_KEEP, CNT_NONE, J_NEXT, PC_LOAD);
      PC_MUL_WB:    w = commit_word(RES_PROD);
      PC_SQUARE:    w = step_word(DP_MUL_SQ, RES_KEEP, CNT_NONE, J_NEXT, PC_LOAD);
      PC_SQUARE_WB: w = commit_word(RES_PROD);
      PC_DIV:       w = step_word(DP_DIV_INIT, RES_KEEP, CNT_DIV, J_NEXT, PC_LOAD);
      PC_DIV_LOOP:  w = step_word(DP_DIV_STEP, RES_KEEP, CNT_NONE, J_LOOP, PC_DIV_LOOP);
      PC_DIV_WB:    w = commit_word(RES_QUO);
      PC_SQRT:      w = step_word(DP_SQRT_INIT, RES_KEEP, CNT_SQRT, J_NEXT, PC_LOAD);
      PC_SQRT_LOOP: w = step_word(DP_SQRT_STEP, RES_KEEP, CNT_NONE, J_LOOP, PC_SQRT_LOOP);
      PC_SQRT_WB:   w = commit_word(RES_ROOT);
      default:      w = step_word(DP_NONE, RES_KEEP, CNT_NONE, J_DONE, PC_LOAD);
    endcase
    return w;
  endfunction

  // dispatch: command to first microcode address
  function automatic logic [PcW-1:0] entry_pc(logic [CmdW-1:0] cmd);
    logic [PcW-1:0] pc;
    pc = PC_KEEP;
    unique case (cmd)
      CMD_LOAD:   pc = PC_LOAD;
      CMD_ADD:    pc = PC_ADD;
      CMD_SUB:    pc = PC_SUB;
      CMD_MUL:    pc = PC_MUL;
      CMD_DIV:    pc = PC_DIV;
      CMD_AND:    pc = PC_AND;
      CMD_OR:     pc = PC_OR;
      CMD_XOR:    pc = PC_XOR;
      CMD_SQRT:   pc = PC_SQRT;
      CMD_SQUARE: pc = PC_SQUARE;
      CMD_SHL:    pc = PC_SHL;
      CMD_SHR:    pc = PC_SHR;
      CMD_NOT:    pc = PC_NOT;
      default:    pc = PC_KEEP;
    endcase
    return pc;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/mwa_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwa_in_if
// Command channel: one command and two operands per item.
// ----------------------------------------------------------------------------
interface mwa_in_if;
  logic                          valid;
  logic                          ready;
  logic [mwa_pkg::CmdW-1:0]      cmd;
  logic [mwa_pkg::OperandW-1:0]  operand_a;
  logic [mwa_pkg::OperandW-1:0]  operand_b;

  modport source (output valid, output cmd, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input cmd, input operand_a, input operand_b,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/mwa_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwa_out_if
// Result channel: the new accumulator value per item.
// ----------------------------------------------------------------------------
interface mwa_out_if;
  logic                          valid;
  logic                          ready;
  logic [mwa_pkg::OperandW-1:0]  result_value;

  modport source (output valid, output result_value, input ready);
  modport sink   (input valid, input result_value, output ready);
endinterface
`default_nettype wire

FILE: rtl/mwa_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwa_cfg_if
// Configuration write channel for the result width register.
// ----------------------------------------------------------------------------
interface mwa_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [mwa_pkg::CfgW-1:0]  result_width;

  modport source (output valid, output result_width, input ready);
  modport sink   (input valid, input result_width, output ready);
endinterface
`default_nettype wire

FILE: rtl/mwa_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwa_sequencer
// Step counter, control store lookup, loop counter and conditional jumps.
// ----------------------------------------------------------------------------
module mwa_sequencer #(
  parameter int DATA_WIDTH = mwa_pkg::DataWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [mwa_pkg::CmdW-1:0] cmd_i,
  output logic                     in_ready_o,
  input  mwa_pkg::dp_status_t      status_i,
  output mwa_pkg::dp_ctrl_t        ctrl_o
);

  localparam int AccW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int SqN  = (AccW + 1) / 2;
  localparam int CntW = $clog2(AccW);
  localparam logic [CntW-1:0] DivCount  = CntW'(AccW - 1);
  localparam logic [CntW-1:0] SqrtCount = CntW'(SqN - 1);

  logic [mwa_pkg::PcW-1:0] pc_q, pc_d;
  logic                    busy_q, busy_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  mwa_pkg::ctl_word_t      ctl;
  logic                    accept;
  logic                    stall;
  logic                    fire;

  assign ctl        = mwa_pkg::rom_word(pc_q);
  assign in_ready_o = ~busy_q;
  assign accept     = in_valid_i & ~busy_q;
  // hold a commit step while the output register is still full
  assign stall      = busy_q & (ctl.dp_op == mwa_pkg::DP_COMMIT) & status_i.out_stall;
  assign fire       = busy_q & ~stall;

  assign ctrl_o.capture = accept;
  assign ctrl_o.fire    = fire;
  assign ctrl_o.dp_op   = ctl.dp_op;
  assign ctrl_o.res_sel = ctl.res_sel;

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (accept) begin
      pc_d   = mwa_pkg::entry_pc(cmd_i);
      busy_d = 1'b1;
    end else if (fire) begin
      unique case (ctl.cnt_sel)
        mwa_pkg::CNT_DIV:  cnt_d = DivCount;
        mwa_pkg::CNT_SQRT: cnt_d = SqrtCount;
        default:           cnt_d = cnt_q;
      endcase
      unique case (ctl.jump)
        mwa_pkg::J_NEXT: pc_d = pc_q + mwa_pkg::PcW'(1);
        mwa_pkg::J_LOOP: begin
          if (cnt_q != '0) begin
            pc_d  = ctl.target;
            cnt_d = cnt_q - CntW'(1);
          end else begin
            pc_d = pc_q + mwa_pkg::PcW'(1);
          end
        end
        mwa_pkg::J_DONE: busy_d = 1'b0;
        default:         busy_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= mwa_pkg::PC_LOAD;
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && ctl.dp_op == mwa_pkg::DP_COMMIT |-> !status_i.out_stall)
    else $error("commit issued into a full output register");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && pc_q == mwa_pkg::entry_pc($past(cmd_i)))
    else $error("accepted item did not start at its dispatch address");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !ctrl_o.fire)
    else $error("datapath step fired while idle");
`endif

endmodule
`default_nettype wire

FILE: rtl/mwa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mwa_datapath
// Operand and accumulator registers, shared multiplier, one-bit divide and
// square root steps, width masking and the output register.
// ----------------------------------------------------------------------------
module mwa_datapath #(
  parameter int DATA_WIDTH = mwa_pkg::DataWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [mwa_pkg::OperandW-1:0] operand_a_i,
  input  logic [mwa_pkg::OperandW-1:0] operand_b_i,
  input  logic                         cfg_valid_i,
  input  logic [mwa_pkg::CfgW-1:0]     cfg_width_i,
  input  mwa_pkg::dp_ctrl_t            ctrl_i,
  output mwa_pkg::dp_status_t          status_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mwa_pkg::OperandW-1:0] out_data_o
);

  localparam int AccW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int SqN  = (AccW + 1) / 2;
  localparam int SqW  = 2 * SqN;
  localparam int RemW = SqN + 2;

  logic [mwa_pkg::CfgW-1:0] rw_q;
  logic [AccW-1:0]          a_q, b_q, acc_q, acc_d;
  logic [AccW-1:0]          prod_q, quo_q, drem_q;
  logic [SqW-1:0]           sx_q;
  logic [RemW-1:0]          srem_q;
  logic [SqN-1:0]           root_q;
  logic                     out_valid_q;
  logic [mwa_pkg::OperandW-1:0] out_data_q;

  logic [mwa_pkg::CfgW-1:0] rw_lo, rw_eff;
  logic [6:0]               mask_sh;
  logic [AccW-1:0]          mask;
  logic [AccW-1:0]          mul_x, mul_y, mul_lo;
  logic [AccW:0]            dsh, dsub;
  logic                     dge;
  logic [RemW-1:0]          ssh, strial, ssub;
  logic                     sge;
  logic [AccW-1:0]          res_v;
  logic                     commit;

  // width 0 acts as 1, anything past the datapath acts as the full width
  assign rw_lo   = (rw_q == '0) ? mwa_pkg::CfgW'(1) : rw_q;
  assign rw_eff  = (rw_lo > mwa_pkg::CfgW'(AccW)) ? mwa_pkg::CfgW'(AccW) : rw_lo;
  assign mask_sh = 7'(AccW) - {1'b0, rw_eff};
  assign mask    = {AccW{1'b1}} >> mask_sh;

  assign mul_x  = (ctrl_i.dp_op == mwa_pkg::DP_MUL_SQ) ? acc_q : a_q;
  assign mul_y  = (ctrl_i.dp_op == mwa_pkg::DP_MUL_SQ) ? acc_q : b_q;
  assign mul_lo = mul_x * mul_y;

  // restoring divide: one quotient bit per step
  assign dsh  = {drem_q, quo_q[AccW-1]};
  assign dge  = dsh >= {1'b0, b_q};
  assign dsub = dsh - {1'b0, b_q};

  // digit-by-digit square root: two radicand bits per step
  assign ssh    = {srem_q[RemW-3:0], sx_q[SqW-1 -: 2]};
  assign strial = {root_q, 2'b01};
  assign sge    = ssh >= strial;
  assign ssub   = ssh - strial;

  assign commit = ctrl_i.fire & (ctrl_i.dp_op == mwa_pkg::DP_COMMIT);

  always_comb begin
    unique case (ctrl_i.res_sel)
      mwa_pkg::RES_A:    res_v = a_q;
      mwa_pkg::RES_ADD:  res_v = a_q + b_q;
      mwa_pkg::RES_SUB:  res_v = a_q - b_q;
      mwa_pkg::RES_PROD: res_v = prod_q;
      mwa_pkg::RES_QUO:  res_v = (b_q == '0) ? '0 : quo_q;
      mwa_pkg::RES_AND:  res_v = a_q & b_q;
      mwa_pkg::RES_OR:   res_v = a_q | b_q;
      mwa_pkg::RES_XOR:  res_v = a_q ^ b_q;
      mwa_pkg::RES_ROOT: res_v = AccW'(root_q);
      mwa_pkg::RES_SHL:  res_v = {acc_q[AccW-2:0], 1'b0};
      mwa_pkg::RES_SHR:  res_v = {1'b0, acc_q[AccW-1:1]};
      mwa_pkg::RES_NOT:  res_v = ~acc_q;
      default:           res_v = acc_q;
    endcase
  end

  // unknown commands keep the accumulator as it stands, without masking
  assign acc_d = (ctrl_i.res_sel == mwa_pkg::RES_KEEP) ? acc_q : (res_v & mask);

  assign status_o.out_stall = out_valid_q & ~out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rw_q        <= mwa_pkg::ResultWidthRst;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        rw_q <= cfg_width_i;
      end
      if (commit) begin
        acc_q       <= acc_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      a_q <= operand_a_i[AccW-1:0];
      b_q <= operand_b_i[AccW-1:0];
    end
    if (commit) begin
      out_data_q <= mwa_pkg::OperandW'(acc_d);
    end
    if (ctrl_i.fire) begin
      unique case (ctrl_i.dp_op)
        mwa_pkg::DP_MUL_AB, mwa_pkg::DP_MUL_SQ: prod_q <= mul_lo;
        mwa_pkg::DP_DIV_INIT: begin
          drem_q <= '0;
          quo_q  <= a_q;
        end
        mwa_pkg::DP_DIV_STEP: begin
          drem_q <= dge ? dsub[AccW-1:0] : dsh[AccW-1:0];
          quo_q  <= {quo_q[AccW-2:0], dge};
        end
        mwa_pkg::DP_SQRT_INIT: begin
          sx_q   <= SqW'(acc_q);
          srem_q <= '0;
          root_q <= '0;
        end
        mwa_pkg::DP_SQRT_STEP: begin
          sx_q   <= {sx_q[SqW-3:0], 2'b00};
          srem_q <= sge ? ssub : ssh;
          root_q <= {root_q[SqN-2:0], sge};
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q)
    else $error("commit did not load the output register");

  a_acc_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && ctrl_i.res_sel != mwa_pkg::RES_KEEP |=> (acc_q & ~$past(mask)) == '0)
    else $error("accumulator holds bits beyond the result width");
`endif

endmodule
`default_nettype wire

FILE: rtl/masked_width_accumulator_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// From accept to result valid: load, logic, add, sub and shifts go straight
// to their commit step; multiply and square run a multiply step first; the
// square root and divide run an init step and a loop before their commit
// step. The divide loop, one quotient bit per step, sets the worst case.
// One item at a time: a new item is accepted once the result is committed.
// Reset (rst_ni low, asynchronous) clears the accumulator, sets width to 32.
// ----------------------------------------------------------------------------
// masked_width_accumulator_alu
// Microcoded accumulator ALU; results of all known commands are width masked.
// ----------------------------------------------------------------------------
module masked_width_accumulator_alu #(
  parameter int DATA_WIDTH = mwa_pkg::DataWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mwa_in_if.sink     in_i,
  mwa_out_if.source  out_o,
  mwa_cfg_if.sink    cfg_i
);

  mwa_pkg::dp_ctrl_t   ctrl;
  mwa_pkg::dp_status_t status;
  logic                in_ready;
  logic                out_valid;
  logic [mwa_pkg::OperandW-1:0] out_data;

  assign in_i.ready         = in_ready;
  assign cfg_i.ready        = 1'b1;
  assign out_o.valid        = out_valid;
  assign out_o.result_value = out_data;

  mwa_sequencer #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .cmd_i      (in_i.cmd),
    .in_ready_o (in_ready),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  mwa_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .operand_a_i (in_i.operand_a),
    .operand_b_i (in_i.operand_b),
    .cfg_valid_i (cfg_i.valid),
    .cfg_width_i (cfg_i.result_width),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_data)
  );

endmodule
`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives commands into the accumulator ALU and predicts each new accumulator
// value. Results are checked in order against the prediction. The width
// register is stepped through its extremes while the ALU is idle. The
// sender and the receiver stall at random in three idling modes.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [mwa_pkg::CmdW-1:0] CmdSpareLo  = 4'd13;
  localparam logic [mwa_pkg::CmdW-1:0] CmdSpareMid = 4'd14;
  localparam logic [mwa_pkg::CmdW-1:0] CmdSpareHi  = 4'd15;
  localparam logic [mwa_pkg::CfgW-1:0] WidthZero   = 6'd0;
  localparam logic [mwa_pkg::CfgW-1:0] WidthOne    = 6'd1;
  localparam logic [mwa_pkg::CfgW-1:0] WidthFull   = 6'd32;
  localparam logic [mwa_pkg::CfgW-1:0] WidthTop    = 6'd63;
  localparam logic [31:0]              AllOnes     = 32'hFFFF_FFFF;
  localparam int                       CycleLimit  = 600000;
  localparam int                       TailCycles  = 40;
  localparam int                       PhaseItems  = 155;

  logic clk_i;
  logic rst_ni;

  mwa_in_if  in_if ();
  mwa_out_if out_if ();
  mwa_cfg_if cfg_if ();

  masked_width_accumulator_alu i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  logic [31:0]              acc_model;
  logic [mwa_pkg::CfgW-1:0] width_model;
  logic [31:0]              pending_results[$];
  int                       error_count;
  int                       cycle_count;
  int                       send_idle_pct;
  int                       recv_idle_pct;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // floor square root, one result bit per pass
  function automatic logic [31:0] floor_root(logic [31:0] x);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int i = 15; i >= 0; i--) begin
      trial = root | (32'h1 << i);
      if ((64'(trial) * 64'(trial)) <= 64'(x)) root = trial;
    end
    return root;
  endfunction

  function automatic logic [31:0] kept_bits(logic [mwa_pkg::CfgW-1:0] w);
    int n;
    n = int'(w);
    if (n < 1) n = 1;
    if (n > 32) n = 32;
    return (n == 32) ? AllOnes : ((32'h1 << n) - 32'h1);
  endfunction

  // advance the accumulator model by one command and return its new value
  function automatic logic [31:0] next_accumulator(logic [mwa_pkg::CmdW-1:0] op,
                                                   logic [31:0] a, logic [31:0] b);
    logic [63:0] wide;
    logic        known;
    known = 1'b1;
    wide  = '0;
    case (op)
      mwa_pkg::CMD_LOAD:   wide = 64'(a);
      mwa_pkg::CMD_ADD:    wide = 64'(a + b);
      mwa_pkg::CMD_SUB:    wide = 64'(a - b);
      mwa_pkg::CMD_MUL:    wide = 64'(a) * 64'(b);
      mwa_pkg::CMD_DIV:    wide = (b == '0) ? 64'd0 : 64'(a / b);
      mwa_pkg::CMD_AND:    wide = 64'(a & b);
      mwa_pkg::CMD_OR:     wide = 64'(a | b);
      mwa_pkg::CMD_XOR:    wide = 64'(a ^ b);
      mwa_pkg::CMD_SQRT:   wide = 64'(floor_root(acc_model));
      mwa_pkg::CMD_SQUARE: wide = 64'(acc_model) * 64'(acc_model);
      mwa_pkg::CMD_SHL:    wide = 64'(acc_model << 1);
      mwa_pkg::CMD_SHR:    wide = 64'(acc_model >> 1);
      mwa_pkg::CMD_NOT:    wide = 64'(~acc_model);
      default:             known = 1'b0;
    endcase
    if (known) acc_model = wide[31:0] & kept_bits(width_model);
    return acc_model;
  endfunction

  task automatic send_op(logic [mwa_pkg::CmdW-1:0] op, logic [31:0] a, logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.cmd       <= op;
    in_if.operand_a <= a;
    in_if.operand_b <= b;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(next_accumulator(op, a, b));
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_result_width(logic [mwa_pkg::CfgW-1:0] w);
    drain_results();
    cfg_if.valid        <= 1'b1;
    cfg_if.result_width <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    width_model = w;
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0:       return '0;
      1:       return AllOnes;
      2:       return 32'($urandom_range(255));
      3:       return 32'h1 << $urandom_range(31);
      4:       return AllOnes >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [mwa_pkg::CmdW-1:0] pick_cmd();
    if ($urandom_range(99) < 8) begin
      return mwa_pkg::CmdW'($urandom_range(CmdSpareHi, CmdSpareLo));
    end
    return mwa_pkg::CmdW'($urandom_range(mwa_pkg::CMD_NOT, mwa_pkg::CMD_LOAD));
  endfunction

  // unary commands on the accumulator straight out of reset
  task automatic test_unary_from_reset();
    send_op(mwa_pkg::CMD_SQRT, AllOnes, AllOnes);
    send_op(mwa_pkg::CMD_NOT, '0, '0);
    send_op(mwa_pkg::CMD_SQRT, '0, '0);
    send_op(mwa_pkg::CMD_SQUARE, '0, '0);
    send_op(mwa_pkg::CMD_SHL, '0, '0);
    send_op(mwa_pkg::CMD_SHR, '0, '0);
  endtask

  task automatic test_binary_extremes();
    send_op(mwa_pkg::CMD_LOAD, AllOnes, '0);
    send_op(mwa_pkg::CMD_ADD, AllOnes, 32'h1);
    send_op(mwa_pkg::CMD_SUB, '0, 32'h1);
    send_op(mwa_pkg::CMD_MUL, AllOnes, AllOnes);
    send_op(mwa_pkg::CMD_DIV, AllOnes, '0);
    send_op(mwa_pkg::CMD_DIV, AllOnes, 32'h1);
    send_op(mwa_pkg::CMD_AND, 32'hAAAA_AAAA, 32'h5555_FFFF);
    send_op(mwa_pkg::CMD_OR, 32'hAAAA_0000, 32'h5555_0000);
    send_op(mwa_pkg::CMD_XOR, AllOnes, 32'h0F0F_0F0F);
  endtask

  // spare codes must return the accumulator untouched, even unmasked
  task automatic test_spare_commands();
    send_op(CmdSpareLo, AllOnes, AllOnes);
    send_op(CmdSpareMid, '0, '0);
    send_op(mwa_pkg::CMD_LOAD, AllOnes, '0);
    write_result_width(6'd5);
    send_op(CmdSpareHi, '0, AllOnes);
  endtask

  task automatic test_width_extremes();
    write_result_width(WidthZero);
    send_op(mwa_pkg::CMD_LOAD, AllOnes, '0);
    send_op(mwa_pkg::CMD_NOT, '0, '0);
    write_result_width(WidthTop);
    send_op(mwa_pkg::CMD_LOAD, AllOnes, '0);
    send_op(mwa_pkg::CMD_SQRT, '0, '0);
    write_result_width(WidthOne);
    send_op(mwa_pkg::CMD_ADD, 32'h1, '0);
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct,
                                     logic [mwa_pkg::CfgW-1:0] w);
    write_result_width(w);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < PhaseItems; i++) begin
      send_op(pick_cmd(), pick_operand(), pick_operand());
    end
  endtask

  // hold ready low for the receiver's idle share of cycles
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    logic [31:0] expected;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time,
                 out_if.result_value);
        error_count++;
      end else begin
        expected = pending_results.pop_front();
        if (out_if.result_value !== expected) begin
          $display("%0t: result_value mismatch, expected %h, got %h", $time,
                   expected, out_if.result_value);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    in_if.valid         = 1'b0;
    in_if.cmd           = mwa_pkg::CMD_LOAD;
    in_if.operand_a     = '0;
    in_if.operand_b     = '0;
    out_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.result_width = mwa_pkg::ResultWidthRst;
    error_count         = 0;
    cycle_count         = 0;
    send_idle_pct       = 14;
    recv_idle_pct       = 70;
    acc_model           = '0;
    width_model         = mwa_pkg::ResultWidthRst;
    rst_ni              = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_unary_from_reset();
    test_binary_extremes();
    test_spare_commands();
    test_width_extremes();

    test_random_traffic(14, 70, WidthFull);
    test_random_traffic(14, 70, mwa_pkg::CfgW'($urandom_range(31, 1)));
    test_random_traffic(70, 14, WidthOne);
    test_random_traffic(70, 14, mwa_pkg::CfgW'($urandom_range(63, 33)));
    test_random_traffic(0, 0, WidthZero);
    test_random_traffic(0, 0, mwa_pkg::CfgW'($urandom_range(63, 0)));

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
